// File: design/rrq_pkg.sv
// Shared types, constants and codes for the reorderable request queue.
`timescale 1ns / 1ps
`default_nettype none

package rrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int POS_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_BITS    = (CNT_BITS > 8) ? CNT_BITS : 8;

  typedef logic [ID_BITS-1:0]  id_t;
  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [CMP_BITS-1:0] cmp_t;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_REORDER = 3'd2,
    OP_UPDATE  = 3'd3,
    OP_START   = 3'd4,
    OP_STOP    = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // What a slot loads at the clock edge.
  typedef enum logic [1:0] {
    SEL_HOLD       = 2'd0,
    SEL_FROM_RIGHT = 2'd1,
    SEL_FROM_LEFT  = 2'd2,
    SEL_LOAD       = 2'd3
  } slot_sel_t;

endpackage

`default_nettype wire

// File: design/rrq_cell.sv
// One queue slot: holds an id, compares it, and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module rrq_cell (
  input  wire logic               clk,
  input  wire rrq_pkg::slot_sel_t sel,
  input  wire rrq_pkg::id_t       left_id,
  input  wire rrq_pkg::id_t       right_id,
  input  wire rrq_pkg::id_t       load_id,
  input  wire rrq_pkg::id_t       cmp_id,
  output rrq_pkg::id_t            id,
  output logic                    match
);

  rrq_pkg::id_t id_next;

  always_comb begin
    case (sel)
      rrq_pkg::SEL_FROM_RIGHT: id_next = right_id;
      rrq_pkg::SEL_FROM_LEFT:  id_next = left_id;
      rrq_pkg::SEL_LOAD:       id_next = load_id;
      default:                 id_next = id;
    endcase
  end

  always_ff @(posedge clk) begin
    id <= id_next;
  end

  assign match = (id == cmp_id);

endmodule

`default_nettype wire

// File: design/reorderable_request_queue.sv
// Top level of the reorderable request queue: command decode and row of slots.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  request  | start in, busy out        | opcode, request_id, target_position,
//           |                           | head_downloaded
//  result   | done out (one-cycle pulse)| start/stop/poll valid+id, head_valid,
//           |                           | head_id, entry_count, status
//  config   | cfg_wr_en in              | cfg_wr_data (requesting_enabled)
//
// A request is captured, and then in the shift cycle every slot compares its
// id against the request in parallel, and the affected slots shift by one
// place or load the request id. The result pulses on done in the cycle after
// that, while a new request may already be captured. busy is high only in the shift cycle.
// Synchronous reset empties the queue and sets requesting_enabled to 1; no
// clearing pass is needed, slots past the count are never read.
// The receiver cannot stall: done is a strobe, and the next request overwrites the results.
`timescale 1ns / 1ps
`default_nettype none

module reorderable_request_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  // request channel
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] request_id,
  input  wire logic [7:0] target_position,
  input  wire logic       head_downloaded,
  // configuration
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  // result channel
  output logic            done,
  output logic            start_valid,
  output logic [7:0]      start_id,
  output logic            stop_valid,
  output logic [7:0]      stop_id,
  output logic            poll_valid,
  output logic [7:0]      poll_id,
  output logic            head_valid,
  output logic [7:0]      head_id,
  output logic [4:0]      entry_count,
  output logic [2:0]      status
);

  localparam int DEPTH = rrq_pkg::QUEUE_DEPTH;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // captured request
  logic [2:0]   op_q;
  rrq_pkg::id_t id_q;
  logic [7:0]   tpos_q;
  logic         dl_q;

  logic         req_en;
  rrq_pkg::cnt_t count, count_next;

  // slot row
  rrq_pkg::id_t      slot_id   [DEPTH];
  rrq_pkg::id_t      left_in   [DEPTH];
  rrq_pkg::id_t      right_in  [DEPTH];
  rrq_pkg::slot_sel_t slot_sel [DEPTH];
  logic [DEPTH-1:0]  slot_match;
  logic [DEPTH-1:0]  hit;

  logic          found;
  rrq_pkg::pos_t at;
  rrq_pkg::pos_t tgt;
  logic          empty;
  logic          push_ok;
  logic          pop_go;
  logic          reorder_go;
  rrq_pkg::id_t  old_head;
  rrq_pkg::id_t  new_head;
  rrq_pkg::cmp_t last_ext;

  // result next values
  logic             sv_next, pv_next, pov_next;
  rrq_pkg::id_t     sid_next, pid_next, poid_next;
  rrq_pkg::status_t st_next;

  assign busy = (state == S_EXEC);

  // ---------------------------------------------------------------- control
  always_comb begin
    unique case (state)
      S_IDLE:  state_next = (start) ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      req_en <= 1'b1;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
      if (state == S_EXEC) begin
        count <= count_next;
      end
      if (cfg_wr_en) begin
        req_en <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q   <= opcode;
      id_q   <= rrq_pkg::id_t'(request_id);
      tpos_q <= target_position;
      dl_q   <= head_downloaded;
    end
  end

  // ------------------------------------------------------------ slot row
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      left_in[i]  = (i == 0)         ? '0 : slot_id[(i == 0) ? 0 : i - 1];
      right_in[i] = (i == DEPTH - 1) ? '0 : slot_id[(i == DEPTH - 1) ? i : i + 1];
    end
  end

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_slot
    rrq_cell u_slot (
      .clk      (clk),
      .sel      (slot_sel[gi]),
      .left_id  (left_in[gi]),
      .right_id (right_in[gi]),
      .load_id  (id_q),
      .cmp_id   (id_q),
      .id       (slot_id[gi]),
      .match    (slot_match[gi])
    );
  end

  // --------------------------------------------------------- search / decode
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = slot_match[i] && (rrq_pkg::cnt_t'(i) < count);
    end
  end

  // lowest matching position (ids are unique, so at most one hit anyway)
  always_comb begin
    at = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        at = rrq_pkg::pos_t'(i);
      end
    end
  end

  assign found    = |hit;
  assign empty    = (count == '0);
  assign old_head = slot_id[0];
  assign last_ext = rrq_pkg::cmp_t'(count) - rrq_pkg::cmp_t'(1);

  // target clamped to the last place of the queue once the id is lifted out
  assign tgt = (rrq_pkg::cmp_t'(tpos_q) >= last_ext) ? rrq_pkg::pos_t'(last_ext)
                                                     : rrq_pkg::pos_t'(tpos_q);

  assign push_ok    = (op_q == rrq_pkg::OP_PUSH) && !found
                      && (count < rrq_pkg::cnt_t'(DEPTH));
  assign pop_go     = !empty && ((op_q == rrq_pkg::OP_POP)
                      || ((op_q == rrq_pkg::OP_UPDATE) && dl_q));
  assign reorder_go = (op_q == rrq_pkg::OP_REORDER) && !empty && found;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_sel[i] = rrq_pkg::SEL_HOLD;
      if (state == S_EXEC) begin
        if (push_ok && (rrq_pkg::cnt_t'(i) == count)) begin
          slot_sel[i] = rrq_pkg::SEL_LOAD;
        end else if (pop_go) begin
          slot_sel[i] = rrq_pkg::SEL_FROM_RIGHT;
        end else if (reorder_go) begin
          if (rrq_pkg::pos_t'(i) == tgt) begin
            slot_sel[i] = rrq_pkg::SEL_LOAD;
          end else if ((at <= tgt) && (rrq_pkg::pos_t'(i) >= at)
                       && (rrq_pkg::pos_t'(i) < tgt)) begin
            slot_sel[i] = rrq_pkg::SEL_FROM_RIGHT;
          end else if ((at > tgt) && (rrq_pkg::pos_t'(i) > tgt)
                       && (rrq_pkg::pos_t'(i) <= at)) begin
            slot_sel[i] = rrq_pkg::SEL_FROM_LEFT;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------- result decode
  always_comb begin
    sv_next    = 1'b0;
    sid_next   = '0;
    pv_next    = 1'b0;
    pid_next   = '0;
    pov_next   = 1'b0;
    poid_next  = '0;
    st_next    = rrq_pkg::ST_OK;
    count_next = count;
    new_head   = old_head;
    case (op_q)
      rrq_pkg::OP_PUSH: begin
        if (found) begin
          st_next = rrq_pkg::ST_DUPLICATE;
        end else if (!push_ok) begin
          st_next = rrq_pkg::ST_FULL;
        end else begin
          count_next = count + rrq_pkg::cnt_t'(1);
          if (empty) begin
            new_head = id_q;
          end
        end
      end
      rrq_pkg::OP_POP, rrq_pkg::OP_UPDATE: begin
        if (empty) begin
          st_next = rrq_pkg::ST_EMPTY;
        end else begin
          if (op_q == rrq_pkg::OP_UPDATE) begin
            pov_next  = 1'b1;
            poid_next = old_head;
          end
          if (pop_go) begin
            count_next = count - rrq_pkg::cnt_t'(1);
            new_head   = slot_id[1];
          end
        end
      end
      rrq_pkg::OP_REORDER: begin
        if (empty) begin
          st_next = rrq_pkg::ST_EMPTY;
        end else if (!found) begin
          st_next = rrq_pkg::ST_NOT_FOUND;
        end else begin
          if (tgt == '0) begin
            new_head = id_q;
          end else if (at == '0) begin
            new_head = slot_id[1];
          end
          // head moved: stop the old one, start the new one
          if (new_head != old_head) begin
            pv_next  = 1'b1;
            pid_next = old_head;
            sv_next  = 1'b1;
            sid_next = new_head;
          end
        end
      end
      rrq_pkg::OP_START: begin
        if (empty) begin
          st_next = rrq_pkg::ST_EMPTY;
        end else if (req_en) begin
          sv_next  = 1'b1;
          sid_next = old_head;
        end
      end
      rrq_pkg::OP_STOP: begin
        if (empty) begin
          st_next = rrq_pkg::ST_EMPTY;
        end else begin
          pv_next  = 1'b1;
          pid_next = old_head;
        end
      end
      default: begin
        st_next = rrq_pkg::ST_OK;
      end
    endcase
  end

  // result register, loaded in the shift cycle and presented with done
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      start_valid <= sv_next;
      start_id    <= 8'(sid_next);
      stop_valid  <= pv_next;
      stop_id     <= 8'(pid_next);
      poll_valid  <= pov_next;
      poll_id     <= 8'(poid_next);
      head_valid  <= (count_next != '0);
      head_id     <= (count_next != '0) ? 8'(new_head) : 8'd0;
      entry_count <= 5'(count_next);
      status      <= st_next;
    end
  end

  // --------------------------------------------------------------- checks
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("done without a shift cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter the shift cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rrq_pkg::cnt_t'(DEPTH))
    else $error("queue count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + rrq_pkg::cnt_t'(1)
                     || count + rrq_pkg::cnt_t'(1) == $past(count)))
    else $error("queue count moved by more than one");

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (head_valid == (entry_count != 5'd0)))
    else $error("head_valid disagrees with entry_count");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the reorderable request queue.
`timescale 1ns / 1ps

module tb;

  // Opcodes 6 and 7 are spare: the block must treat them as no-ops.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int SETTLE_CYCLES = 4;    // quiet cycles before a register write
  localparam int DRAIN_CYCLES  = 8;    // tail after the last result
  localparam int CHUNK_ITEMS   = 232;  // least requests per random chunk
  localparam int POOL_SIZE     = 20;   // ids in play per chunk
  localparam int MAX_PRINTS    = 100;

  // One line of the stimulus plan: either a request or a register write.
  typedef struct {
    logic          is_cfg;
    logic          cfg_val;
    int unsigned   gap_pct;
    logic [2:0]    op;
    rrq_pkg::id_t  rid;
    logic [7:0]    tpos;
    logic          dl;
  } plan_entry_t;

  // Everything the block should report for one request.
  typedef struct {
    int            seq;
    logic          start_v;
    rrq_pkg::id_t  start_i;
    logic          stop_v;
    rrq_pkg::id_t  stop_i;
    logic          poll_v;
    rrq_pkg::id_t  poll_i;
    logic          head_v;
    rrq_pkg::id_t  head_i;
    rrq_pkg::cnt_t count;
    logic [2:0]    stat;
  } queue_outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] opcode = '0;
  logic [7:0] request_id = '0;
  logic [7:0] target_position = '0;
  logic       head_downloaded = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       done;
  logic       start_valid;
  logic [7:0] start_id;
  logic       stop_valid;
  logic [7:0] stop_id;
  logic       poll_valid;
  logic [7:0] poll_id;
  logic       head_valid;
  logic [7:0] head_id;
  logic [4:0] entry_count;
  logic [2:0] status;

  reorderable_request_queue dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .request_id      (request_id),
    .target_position (target_position),
    .head_downloaded (head_downloaded),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .done            (done),
    .start_valid     (start_valid),
    .start_id        (start_id),
    .stop_valid      (stop_valid),
    .stop_id         (stop_id),
    .poll_valid      (poll_valid),
    .poll_id         (poll_id),
    .head_valid      (head_valid),
    .head_id         (head_id),
    .entry_count     (entry_count),
    .status          (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the queue and the enable bit.
  // ---------------------------------------------------------------------
  rrq_pkg::id_t   held_ids[$];
  logic           requesting_en = 1'b1;
  plan_entry_t    request_plan[$];
  queue_outcome_t expected_results[$];
  plan_entry_t    in_flight;
  int             requests_total = 0;
  int             requests_taken = 0;
  int             results_seen = 0;
  int             errors = 0;
  int             quiet = 0;

  // stimulus generation state
  int unsigned    gap_pct = 26;
  rrq_pkg::id_t   id_pool[POOL_SIZE];

  function automatic int find_held(rrq_pkg::id_t rid);
    for (int i = 0; i < held_ids.size(); i++)
      if (held_ids[i] == rid) return i;
    return -1;
  endfunction

  // Applies one request to the predicted queue and returns what the block
  // should report for it.
  function automatic queue_outcome_t predict_queue_op(plan_entry_t req);
    queue_outcome_t res;
    int             at;
    int             pos;
    rrq_pkg::id_t   old_head;
    res = '{default: '0};
    res.stat = rrq_pkg::ST_OK;
    case (req.op)
      rrq_pkg::OP_PUSH: begin
        if (find_held(req.rid) >= 0) res.stat = rrq_pkg::ST_DUPLICATE;
        else if (held_ids.size() >= rrq_pkg::QUEUE_DEPTH) res.stat = rrq_pkg::ST_FULL;
        else held_ids = {held_ids, req.rid};
      end
      rrq_pkg::OP_POP: begin
        if (held_ids.size() == 0) res.stat = rrq_pkg::ST_EMPTY;
        else held_ids.delete(0);
      end
      rrq_pkg::OP_REORDER: begin
        if (held_ids.size() == 0) begin
          res.stat = rrq_pkg::ST_EMPTY;
        end else begin
          at = find_held(req.rid);
          old_head = held_ids[0];
          if (at < 0) begin
            res.stat = rrq_pkg::ST_NOT_FOUND;
          end else begin
            held_ids.delete(at);
            // positions past the end clamp to the tail
            pos = (req.tpos >= held_ids.size()) ? held_ids.size() : int'(req.tpos);
            held_ids.insert(pos, req.rid);
            // new head: stop the old one, start the new one
            if (held_ids[0] != old_head) begin
              res.stop_v  = 1'b1;
              res.stop_i  = old_head;
              res.start_v = 1'b1;
              res.start_i = held_ids[0];
            end
          end
        end
      end
      rrq_pkg::OP_UPDATE: begin
        if (held_ids.size() == 0) begin
          res.stat = rrq_pkg::ST_EMPTY;
        end else begin
          res.poll_v = 1'b1;
          res.poll_i = held_ids[0];
          if (req.dl) held_ids.delete(0);   // finished: drop it, no commands
        end
      end
      rrq_pkg::OP_START: begin
        if (held_ids.size() == 0) begin
          res.stat = rrq_pkg::ST_EMPTY;
        end else if (requesting_en) begin
          res.start_v = 1'b1;
          res.start_i = held_ids[0];
        end
      end
      rrq_pkg::OP_STOP: begin
        if (held_ids.size() == 0) begin
          res.stat = rrq_pkg::ST_EMPTY;
        end else begin
          res.stop_v = 1'b1;
          res.stop_i = held_ids[0];
        end
      end
      default: ;   // spare opcodes
    endcase
    res.head_v = (held_ids.size() != 0);
    res.head_i = res.head_v ? held_ids[0] : '0;
    res.count  = rrq_pkg::cnt_t'(held_ids.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input int seq, input string name,
                             input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("request %0d: %s is %0h, expected %0h",
                                seq, name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Stimulus plan helpers
  // ---------------------------------------------------------------------
  task automatic add_req(input logic [2:0] op, input rrq_pkg::id_t rid,
                         input logic [7:0] tpos, input logic dl);
    plan_entry_t e;
    e.is_cfg  = 1'b0;
    e.cfg_val = 1'b0;
    e.gap_pct = gap_pct;
    e.op      = op;
    e.rid     = rid;
    e.tpos    = tpos;
    e.dl      = dl;
    request_plan = {request_plan, e};
    requests_total++;
  endtask

  task automatic add_cfg(input logic val);
    plan_entry_t e;
    e = '{default: '0};
    e.is_cfg  = 1'b1;
    e.cfg_val = val;
    request_plan = {request_plan, e};
  endtask

  // Mostly ids from a small pool, so duplicates and reorder hits are common.
  function automatic rrq_pkg::id_t pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return rrq_pkg::id_t'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_pos();
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, rrq_pkg::QUEUE_DEPTH));
    return 8'($urandom_range(0, 255));
  endfunction

  // One burst of related requests; returns how many it added.
  task automatic add_episode(input int unsigned chunk_gap, output int counted);
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    counted = 0;
    gap_pct = chunk_gap;
    kind = $urandom_range(0, 9);
    n = $urandom_range(5, 24);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (kind < 2) begin
        // fill: mostly pushes, so the queue runs full
        if (r < 85) add_req(rrq_pkg::OP_PUSH, pick_id(), pick_pos(), 1'($urandom));
        else add_req(rrq_pkg::OP_REORDER, pick_id(), pick_pos(), 1'($urandom));
        counted++;
      end else if (kind < 3) begin
        // drain: pops and finished updates, runs past empty
        if (r < 40) add_req(rrq_pkg::OP_POP, pick_id(), pick_pos(), 1'($urandom));
        else add_req(rrq_pkg::OP_UPDATE, pick_id(), pick_pos(), r < 90);
        counted++;
      end else begin
        if (r < 28) add_req(rrq_pkg::OP_PUSH, pick_id(), pick_pos(), 1'($urandom));
        else if (r < 38) add_req(rrq_pkg::OP_POP, pick_id(), pick_pos(), 1'($urandom));
        else if (r < 62) add_req(rrq_pkg::OP_REORDER, pick_id(), pick_pos(), 1'($urandom));
        else if (r < 77) add_req(rrq_pkg::OP_UPDATE, pick_id(), pick_pos(), 1'($urandom));
        else if (r < 87) add_req(rrq_pkg::OP_START, pick_id(), pick_pos(), 1'($urandom));
        else if (r < 97) add_req(rrq_pkg::OP_STOP, pick_id(), pick_pos(), 1'($urandom));
        else add_req(r[0] ? OP_SPARE_A : OP_SPARE_B, pick_id(), pick_pos(), 1'($urandom));
        counted++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: one request in flight at most; register writes only once the
  // block has gone quiet.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic           fire;
    logic           hold;
    logic           go;
    logic           wr;
    queue_outcome_t res;
    if (rst) begin
      start     <= 1'b0;
      cfg_wr_en <= 1'b0;
      quiet     = 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        res = predict_queue_op(in_flight);
        res.seq = requests_taken;
        requests_taken++;
        expected_results = {expected_results, res};
      end
      hold  = start && !fire;
      quiet = (expected_results.size() == 0 && !start) ? quiet + 1 : 0;
      go    = hold;
      wr    = 1'b0;
      if (!hold && request_plan.size() != 0) begin
        if (request_plan[0].is_cfg) begin
          if (quiet >= SETTLE_CYCLES) begin
            wr            = 1'b1;
            cfg_wr_data   <= request_plan[0].cfg_val;
            requesting_en = request_plan[0].cfg_val;
            request_plan.delete(0);
            quiet = 0;
          end
        end else if ($urandom_range(0, 99) >= request_plan[0].gap_pct) begin
          in_flight = request_plan[0];
          request_plan.delete(0);
          go = 1'b1;
          opcode          <= in_flight.op;
          request_id      <= in_flight.rid;
          target_position <= in_flight.tpos;
          head_downloaded <= in_flight.dl;
        end
      end
      start     <= go;
      cfg_wr_en <= wr;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every done strobe is checked against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    queue_outcome_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field(want.seq, "start_valid", start_valid, want.start_v);
        check_field(want.seq, "start_id", start_id, want.start_i);
        check_field(want.seq, "stop_valid", stop_valid, want.stop_v);
        check_field(want.seq, "stop_id", stop_id, want.stop_i);
        check_field(want.seq, "poll_valid", poll_valid, want.poll_v);
        check_field(want.seq, "poll_id", poll_id, want.poll_i);
        check_field(want.seq, "head_valid", head_valid, want.head_v);
        check_field(want.seq, "head_id", head_id, want.head_i);
        check_field(want.seq, "entry_count", entry_count, want.count);
        check_field(want.seq, "status", status, want.stat);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------
  initial begin
    int unsigned chunk_gap[6];
    logic        chunk_cfg[6];
    int          counted;
    int          got;
    chunk_gap = '{26, 26, 88, 88, 0, 0};
    chunk_cfg = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

    // directed: empty-queue cases first, then the named corner cases
    gap_pct = 26;
    add_cfg(1'b1);
    add_req(rrq_pkg::OP_POP, 8'h00, 8'h00, 1'b0);
    add_req(rrq_pkg::OP_UPDATE, 8'h00, 8'h00, 1'b1);
    add_req(rrq_pkg::OP_START, 8'h00, 8'h00, 1'b0);
    add_req(rrq_pkg::OP_STOP, 8'h00, 8'h00, 1'b0);
    add_req(rrq_pkg::OP_REORDER, 8'h00, 8'hFF, 1'b0);
    add_req(OP_SPARE_A, 8'hFF, 8'hFF, 1'b1);
    add_req(rrq_pkg::OP_PUSH, 8'h00, 8'h00, 1'b0);
    add_req(rrq_pkg::OP_PUSH, 8'hFF, 8'hFF, 1'b1);
    add_req(rrq_pkg::OP_PUSH, 8'hA5, 8'h5A, 1'b0);
    add_req(rrq_pkg::OP_PUSH, 8'hFF, 8'h00, 1'b0);      // duplicate
    add_req(rrq_pkg::OP_REORDER, 8'h3C, 8'h00, 1'b0);   // id not queued
    add_req(rrq_pkg::OP_REORDER, 8'hA5, 8'h00, 1'b0);   // head changes
    add_req(rrq_pkg::OP_REORDER, 8'h00, 8'hFF, 1'b0);   // past the end: to the tail
    add_req(rrq_pkg::OP_REORDER, 8'hFF, 8'h01, 1'b0);   // head unchanged
    add_req(rrq_pkg::OP_START, 8'h00, 8'h00, 1'b0);
    add_req(rrq_pkg::OP_STOP, 8'h00, 8'h00, 1'b0);
    add_req(OP_SPARE_B, 8'h00, 8'h00, 1'b0);
    add_cfg(1'b0);
    add_req(rrq_pkg::OP_START, 8'h00, 8'h00, 1'b0);     // requesting disabled
    add_cfg(1'b1);
    add_req(rrq_pkg::OP_UPDATE, 8'h00, 8'h00, 1'b0);    // polled, stays
    add_req(rrq_pkg::OP_UPDATE, 8'h00, 8'h00, 1'b1);    // polled, removed
    add_req(rrq_pkg::OP_POP, 8'h00, 8'h00, 1'b0);

    // random chunks, each with its own enable setting and sender gaps
    for (int c = 0; c < 6; c++) begin
      foreach (id_pool[i]) id_pool[i] = rrq_pkg::id_t'($urandom_range(0, 255));
      add_cfg(chunk_cfg[c]);
      counted = 0;
      while (counted < CHUNK_ITEMS) begin
        add_episode(chunk_gap[c], got);
        counted += got;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (results_seen < requests_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("predicted results never arrived");
    if (errors == 0) begin
      $display("reorderable_request_queue verification clean");
    end else begin
      $display("reorderable_request_queue verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("reorderable_request_queue verification failed");
    $finish;
  end

endmodule

// File: sim.f
design/rrq_pkg.sv
design/rrq_cell.sv
design/reorderable_request_queue.sv
tb/tb.sv
